// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL of the sorter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/srt_pkg.sv =====
// Shared types and constants of the insertion sorter.
`default_nettype none

package srt_pkg;

  localparam int MAX_ELEMENTS = 16;
  localparam int VALUE_W      = 32;
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } state_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                      insert;
    logic                      shift_down;
    logic signed [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/srt_cell.sv =====
// One cell of the sorting chain: holds a single stored value.
`default_nettype none

module srt_cell (
  input  wire logic                              clk_i,
  input  wire srt_pkg::cell_ctrl_t               ctrl_i,
  input  wire logic                              occupied_i,
  input  wire logic                              prev_gt_i,
  input  wire logic signed [srt_pkg::VALUE_W-1:0] prev_value_i,
  input  wire logic signed [srt_pkg::VALUE_W-1:0] next_value_i,
  output logic signed [srt_pkg::VALUE_W-1:0]      value_o,
  output logic                                   gt_o
);

  logic signed [srt_pkg::VALUE_W-1:0] value_q;
  logic signed [srt_pkg::VALUE_W-1:0] value_d;

  // An empty cell behaves as if it held a value above everything.
  assign gt_o    = !occupied_i || (value_q > ctrl_i.value);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    priority if (ctrl_i.insert && gt_o) begin
      // Either the neighbor's value moves up into this cell, or the new value lands here.
      value_d = prev_gt_i ? prev_value_i : ctrl_i.value;
    end else if (ctrl_i.shift_down) begin
      value_d = next_value_i;
    end else begin
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/insertion_sorter.sv =====
// Top level of the insertion sorter: cell chain, fill count and drain control.
//
// Usage: present a signed value on value_i with end_of_set_i and raise start.
// A transaction is accepted at a rising edge where start is high and busy is
// low. While a set is being collected, busy stays low and one value is taken
// every cycle; a chain of MAX_ELEMENTS cells compares all stored entries with
// the new value in parallel and shifts larger ones up one place in that cycle.
// Values that arrive while the chain is full are discarded and the set is
// flagged as dropped.
// The transaction carrying end_of_set_i closes the set. From the next cycle on
// the chain shifts down one cell per cycle and cell 0 is shown on the result
// ports with result_valid_o for exactly one cycle each, once per stored value,
// the largest one flagged by last_result_o. busy is high while the stored
// values are emitted. The receiver cannot stall the results.
// Reset empties the chain and clears the drop flag; the next set can start
// in the first cycle after reset is released.
`default_nettype none
`include "assert_macros.svh"

module insertion_sorter (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [srt_pkg::VALUE_W-1:0] value_i,
  input  wire logic                               end_of_set_i,
  output logic                                    result_valid_o,
  output logic signed [srt_pkg::VALUE_W-1:0]      sorted_value_o,
  output logic                                    last_result_o,
  output logic                                    dropped_o
);

  srt_pkg::state_e            state_q, state_d;
  logic [srt_pkg::CNT_W-1:0]  fill_q, fill_d;
  logic                       overflow_q, overflow_d;
  logic                       accept;
  logic                       full;
  logic                       last_out;
  srt_pkg::cell_ctrl_t        ctrl;

  logic signed [srt_pkg::VALUE_W-1:0] cell_value [srt_pkg::MAX_ELEMENTS];
  logic                               cell_gt    [srt_pkg::MAX_ELEMENTS];

  assign accept   = start && !busy;
  assign full     = (fill_q == srt_pkg::CNT_W'(srt_pkg::MAX_ELEMENTS));
  assign last_out = (fill_q == srt_pkg::CNT_W'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srt_pkg::ST_COLLECT: begin
        if (accept && end_of_set_i) state_d = srt_pkg::ST_DRAIN;
      end
      srt_pkg::ST_DRAIN: begin
        if (last_out) state_d = srt_pkg::ST_COLLECT;
      end
      default: state_d = srt_pkg::ST_COLLECT;
    endcase
  end

  // Outputs and chain commands.
  always_comb begin
    busy            = 1'b0;
    result_valid_o  = 1'b0;
    ctrl.insert     = 1'b0;
    ctrl.shift_down = 1'b0;
    ctrl.value      = value_i;
    unique case (state_q)
      srt_pkg::ST_COLLECT: begin
        ctrl.insert = accept && !full;
      end
      srt_pkg::ST_DRAIN: begin
        busy            = 1'b1;
        result_valid_o  = 1'b1;
        ctrl.shift_down = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  assign sorted_value_o = cell_value[0];
  assign last_result_o  = result_valid_o && last_out;
  assign dropped_o      = overflow_q;

  always_comb begin
    fill_d     = fill_q;
    overflow_d = overflow_q;
    if (ctrl.insert) fill_d = fill_q + srt_pkg::CNT_W'(1);
    if (accept && full) overflow_d = 1'b1;
    if (ctrl.shift_down) begin
      fill_d = fill_q - srt_pkg::CNT_W'(1);
      if (last_out) overflow_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= srt_pkg::ST_COLLECT;
      fill_q     <= '0;
      overflow_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      overflow_q <= overflow_d;
    end
  end

  for (genvar i = 0; i < srt_pkg::MAX_ELEMENTS; i++) begin : g_cell
    logic                               prev_gt;
    logic signed [srt_pkg::VALUE_W-1:0] prev_value;
    logic signed [srt_pkg::VALUE_W-1:0] next_value;

    if (i == 0) begin : g_head
      assign prev_gt    = 1'b0;
      assign prev_value = value_i;
    end else begin : g_body
      assign prev_gt    = cell_gt[i-1];
      assign prev_value = cell_value[i-1];
    end

    if (i == srt_pkg::MAX_ELEMENTS - 1) begin : g_tail
      assign next_value = cell_value[i];
    end else begin : g_inner
      assign next_value = cell_value[i+1];
    end

    srt_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (fill_q > srt_pkg::CNT_W'(i)),
      .prev_gt_i    (prev_gt),
      .prev_value_i (prev_value),
      .next_value_i (next_value),
      .value_o      (cell_value[i]),
      .gt_o         (cell_gt[i])
    );
  end

  `ASSERT_IMPLIES(a_fill_bound, clk_i, rst_ni, 1'b1,
                  fill_q <= srt_pkg::CNT_W'(srt_pkg::MAX_ELEMENTS))
  `ASSERT_IMPLIES(a_result_nonempty, clk_i, rst_ni, result_valid_o, fill_q != '0)
  `ASSERT_NEXT(a_close_starts_drain, clk_i, rst_ni, accept && end_of_set_i, result_valid_o)
  `ASSERT_NEXT(a_last_ends_set, clk_i, rst_ni, last_result_o, !busy && fill_q == '0 && !dropped_o)

endmodule

`default_nettype wire
